// ===== sv/dht_pkg.sv =====
// Shared types, codes and defaults for the double-hashing key table.
package dht_pkg;

   localparam int TABLE_SLOTS = 1021;
   localparam int KEY_WIDTH   = 31;
   localparam int OP_WIDTH    = 2;
   localparam int TAG_WIDTH   = 2;
   localparam int SLOT_WIDTH  = TAG_WIDTH + KEY_WIDTH;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [OP_WIDTH-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_SEARCH = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_DELETE = 2'd2;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_DUPLICATE = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [TAG_WIDTH-1:0] {
      TAG_EMPTY = 2'd0,
      TAG_TOMB  = 2'd1,
      TAG_USED  = 2'd2
   } tag_type;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_MULTIPLY,
      FR_SUBTRACT,
      FR_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_READ,
      BK_CHECK,
      BK_DECIDE
   } back_state_type;

endpackage

// ===== sv/dht_front.sv =====
// Front end: accepts requests and reduces the key to its first probe and step.
module dht_front #(
   parameter int TABLE_SLOTS = dht_pkg::TABLE_SLOTS,
   localparam int AW = $clog2(TABLE_SLOTS)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [dht_pkg::OP_WIDTH-1:0]  in_op,
   input  logic [dht_pkg::KEY_WIDTH-1:0] in_key,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [dht_pkg::OP_WIDTH-1:0]  out_op,
   output logic [dht_pkg::KEY_WIDTH-1:0] out_key,
   output logic [AW-1:0]                 out_pos,
   output logic [AW-1:0]                 out_step
);

   localparam int SW = AW + 1;
   localparam int KW = dht_pkg::KEY_WIDTH;
   localparam logic [SW-1:0] MOD_A    = SW'(TABLE_SLOTS);
   localparam logic [SW-1:0] MOD_B    = SW'(TABLE_SLOTS - 1);
   localparam logic [KW:0]   KEY_SPAN = {1'b1, {KW{1'b0}}};
   localparam logic [KW-1:0] RECIP_A  = KW'(KEY_SPAN / {{(KW + 1 - SW){1'b0}}, MOD_A});
   localparam logic [KW-1:0] RECIP_B  = KW'(KEY_SPAN / {{(KW + 1 - SW){1'b0}}, MOD_B});

   // The estimated quotient is at most one below the true one, so one
   // compare and subtract finishes each remainder.
   dht_pkg::front_state_type state_ff, state_in;
   logic [dht_pkg::OP_WIDTH-1:0] op_ff, op_in;
   logic [KW-1:0]                key_ff, key_in;
   logic [KW-1:0]                quot_a_ff, quot_a_in;
   logic [KW-1:0]                quot_b_ff, quot_b_in;
   logic [SW-1:0]                rem_a_ff, rem_a_in;
   logic [SW-1:0]                rem_b_ff, rem_b_in;
   logic [2*KW-1:0]              prod_a, prod_b;
   logic [KW+SW-1:0]             back_a, back_b;
   logic [KW-1:0]                diff_a, diff_b;
   logic [AW-1:0]                fix_a, fix_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dht_pkg::FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff     <= op_in;
      key_ff    <= key_in;
      quot_a_ff <= quot_a_in;
      quot_b_ff <= quot_b_in;
      rem_a_ff  <= rem_a_in;
      rem_b_ff  <= rem_b_in;
   end

   assign prod_a = {{KW{1'b0}}, key_ff} * {{KW{1'b0}}, RECIP_A};
   assign prod_b = {{KW{1'b0}}, key_ff} * {{KW{1'b0}}, RECIP_B};
   assign back_a = {{SW{1'b0}}, quot_a_ff} * {{KW{1'b0}}, MOD_A};
   assign back_b = {{SW{1'b0}}, quot_b_ff} * {{KW{1'b0}}, MOD_B};
   assign diff_a = key_ff - back_a[KW-1:0];
   assign diff_b = key_ff - back_b[KW-1:0];
   assign fix_a  = (rem_a_ff >= MOD_A) ? AW'(rem_a_ff - MOD_A) : AW'(rem_a_ff);
   assign fix_b  = (rem_b_ff >= MOD_B) ? AW'(rem_b_ff - MOD_B) : AW'(rem_b_ff);

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      key_in    = key_ff;
      quot_a_in = quot_a_ff;
      quot_b_in = quot_b_ff;
      rem_a_in  = rem_a_ff;
      rem_b_in  = rem_b_ff;
      in_ready  = 1'b0;
      out_valid = 1'b0;
      unique case (state_ff)
         dht_pkg::FR_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               op_in    = in_op;
               key_in   = in_key;
               state_in = dht_pkg::FR_MULTIPLY;
            end
         end
         dht_pkg::FR_MULTIPLY: begin
            quot_a_in = prod_a[2*KW-1:KW];
            quot_b_in = prod_b[2*KW-1:KW];
            state_in  = dht_pkg::FR_SUBTRACT;
         end
         dht_pkg::FR_SUBTRACT: begin
            rem_a_in = diff_a[SW-1:0];
            rem_b_in = diff_b[SW-1:0];
            state_in = dht_pkg::FR_PUSH;
         end
         dht_pkg::FR_PUSH: begin
            out_valid = 1'b1;
            if (out_ready) begin
               state_in = dht_pkg::FR_IDLE;
            end
         end
         default: begin
            state_in = dht_pkg::FR_IDLE;
         end
      endcase
   end

   assign out_op   = op_ff;
   assign out_key  = key_ff;
   assign out_pos  = fix_a;
   assign out_step = AW'(MOD_B - {1'b0, fix_b});

endmodule

// ===== sv/dht_queue.sv =====
// Short request queue between the front end and the probe engine.
module dht_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = dht_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             push, pop;

   assign in_ready  = (count_ff != CW'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// ===== sv/dht_back.sv =====
// Probe engine: walks the probe path in the slot memory and applies each request.
module dht_back #(
   parameter int TABLE_SLOTS = dht_pkg::TABLE_SLOTS,
   localparam int AW = $clog2(TABLE_SLOTS)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [dht_pkg::OP_WIDTH-1:0]  in_op,
   input  logic [dht_pkg::KEY_WIDTH-1:0] in_key,
   input  logic [AW-1:0]                 in_pos,
   input  logic [AW-1:0]                 in_step,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output dht_pkg::status_type           rsp_status,
   output logic                          rsp_found,
   output logic                          clearing
);

   localparam int SW = AW + 1;
   localparam int CW = $clog2(TABLE_SLOTS + 1);
   localparam int KW = dht_pkg::KEY_WIDTH;
   localparam logic [SW-1:0] SLOTS_W = SW'(TABLE_SLOTS);

   logic [dht_pkg::SLOT_WIDTH-1:0] slot_mem [TABLE_SLOTS];
   logic [dht_pkg::SLOT_WIDTH-1:0] rd_data_ff;

   dht_pkg::back_state_type state_ff, state_in;
   logic [AW-1:0]                clr_idx_ff, clr_idx_in;
   logic [dht_pkg::OP_WIDTH-1:0] op_ff, op_in;
   logic [KW-1:0]                key_ff, key_in;
   logic [AW-1:0]                pos_ff, pos_in;
   logic [AW-1:0]                step_ff, step_in;
   logic [AW-1:0]                probe_ff, probe_in;
   logic [AW-1:0]                free_ff, free_in;
   logic                         free_vld_ff, free_vld_in;
   logic                         present_ff, present_in;
   logic [CW-1:0]                count_ff, count_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   dht_pkg::status_type          rsp_status_ff, rsp_status_in;
   logic                         rsp_found_ff, rsp_found_in;

   logic                           wr_en;
   logic [AW-1:0]                  wr_addr;
   logic [dht_pkg::SLOT_WIDTH-1:0] wr_data;
   logic [dht_pkg::TAG_WIDTH-1:0]  rd_tag;
   logic [KW-1:0]                  rd_key;
   logic [SW-1:0]                  pos_sum;
   logic [AW-1:0]                  pos_next;
   logic                           rsp_free;
   logic                           table_full;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= slot_mem[pos_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dht_pkg::BK_CLEAR;
         clr_idx_ff   <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      pos_ff        <= pos_in;
      step_ff       <= step_in;
      probe_ff      <= probe_in;
      free_ff       <= free_in;
      free_vld_ff   <= free_vld_in;
      present_ff    <= present_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
   end

   assign rd_tag     = rd_data_ff[dht_pkg::SLOT_WIDTH-1 -: dht_pkg::TAG_WIDTH];
   assign rd_key     = rd_data_ff[KW-1:0];
   assign pos_sum    = {1'b0, pos_ff} + {1'b0, step_ff};
   assign pos_next   = (pos_sum >= SLOTS_W) ? AW'(pos_sum - SLOTS_W) : AW'(pos_sum);
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign table_full = (count_ff >= CW'(TABLE_SLOTS));

   always_comb begin
      state_in      = state_ff;
      clr_idx_in    = clr_idx_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      pos_in        = pos_ff;
      step_in       = step_ff;
      probe_in      = probe_ff;
      free_in       = free_ff;
      free_vld_in   = free_vld_ff;
      present_in    = present_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      in_ready      = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_data       = {dht_pkg::TAG_USED, key_ff};
      unique case (state_ff)
         dht_pkg::BK_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_idx_ff;
            wr_data = {dht_pkg::TAG_EMPTY, {KW{1'b0}}};
            if (clr_idx_ff == AW'(TABLE_SLOTS - 1)) begin
               state_in = dht_pkg::BK_IDLE;
            end else begin
               clr_idx_in = clr_idx_ff + 1'b1;
            end
         end
         dht_pkg::BK_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               op_in       = in_op;
               key_in      = in_key;
               pos_in      = in_pos;
               step_in     = in_step;
               probe_in    = '0;
               free_vld_in = 1'b0;
               present_in  = 1'b0;
               state_in    = dht_pkg::BK_READ;
            end
         end
         dht_pkg::BK_READ: begin
            state_in = dht_pkg::BK_CHECK;
         end
         dht_pkg::BK_CHECK: begin
            if (rd_tag == dht_pkg::TAG_USED && rd_key == key_ff) begin
               present_in = 1'b1;
               state_in   = dht_pkg::BK_DECIDE;
            end else if (rd_tag == dht_pkg::TAG_EMPTY) begin
               if (!free_vld_ff) begin
                  free_in     = pos_ff;
                  free_vld_in = 1'b1;
               end
               state_in = dht_pkg::BK_DECIDE;
            end else begin
               if (rd_tag != dht_pkg::TAG_USED && !free_vld_ff) begin
                  free_in     = pos_ff;
                  free_vld_in = 1'b1;
               end
               if (probe_ff == AW'(TABLE_SLOTS - 1)) begin
                  state_in = dht_pkg::BK_DECIDE;
               end else begin
                  probe_in = probe_ff + 1'b1;
                  pos_in   = pos_next;
                  state_in = dht_pkg::BK_READ;
               end
            end
         end
         dht_pkg::BK_DECIDE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = present_ff;
               state_in     = dht_pkg::BK_IDLE;
               if (op_ff == dht_pkg::OP_INSERT) begin
                  if (table_full) begin
                     rsp_status_in = dht_pkg::ST_FULL;
                  end else if (present_ff) begin
                     rsp_status_in = dht_pkg::ST_DUPLICATE;
                  end else if (free_vld_ff) begin
                     rsp_status_in = dht_pkg::ST_DONE;
                     wr_en         = 1'b1;
                     wr_addr       = free_ff;
                     wr_data       = {dht_pkg::TAG_USED, key_ff};
                     count_in      = count_ff + 1'b1;
                  end else begin
                     rsp_status_in = dht_pkg::ST_FULL;
                  end
               end else if (op_ff == dht_pkg::OP_DELETE) begin
                  if (present_ff) begin
                     rsp_status_in = dht_pkg::ST_DONE;
                     wr_en         = 1'b1;
                     wr_addr       = pos_ff;
                     wr_data       = {dht_pkg::TAG_TOMB, key_ff};
                     if (count_ff != '0) begin
                        count_in = count_ff - 1'b1;
                     end
                  end else begin
                     rsp_status_in = dht_pkg::ST_NOT_FOUND;
                  end
               end else begin
                  rsp_status_in = present_ff ? dht_pkg::ST_DONE : dht_pkg::ST_NOT_FOUND;
               end
            end
         end
         default: begin
            state_in = dht_pkg::BK_IDLE;
         end
      endcase
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_found  = rsp_found_ff;
   assign clearing   = (state_ff == dht_pkg::BK_CLEAR);

endmodule

// ===== sv/double_hash_table.sv =====
// Top level of the double-hashing open-addressing key table.
// A set of TABLE_SLOTS keys (TABLE_SLOTS prime) that takes insert, search and delete
// requests and answers each with one status and a found flag, in request order. After
// reset the slot memory is cleared one slot per cycle, and req_tready stays low during
// that pass. The front end reduces each key to its first probe and step by reciprocal
// multiplication in its MULTIPLY and SUBTRACT states, and takes no new request until
// it has pushed the last one. The probe engine reads one slot per probe through a
// single registered memory port; each probe passes its READ and CHECK states, and each
// request ends in a DECIDE state, so it takes no new request until it has answered the
// last. The two run overlapped through a two-entry queue.
module double_hash_table #(
   parameter int TABLE_SLOTS = dht_pkg::TABLE_SLOTS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // key [30:0], zero [31]
   input  logic [1:0]  req_tuser,  // operation [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata   // status [1:0], found [2], zero [7:3]
);

   localparam int AW = $clog2(TABLE_SLOTS);
   localparam int QW = dht_pkg::OP_WIDTH + dht_pkg::KEY_WIDTH + 2 * AW;

   logic                          clearing;
   logic                          fr_in_valid, fr_in_ready;
   logic                          fr_out_valid, fr_out_ready;
   logic [dht_pkg::OP_WIDTH-1:0]  fr_op;
   logic [dht_pkg::KEY_WIDTH-1:0] fr_key;
   logic [AW-1:0]                 fr_pos, fr_step;
   logic [QW-1:0]                 q_in_data, q_out_data;
   logic                          q_out_valid, q_out_ready;
   dht_pkg::status_type           bk_status;
   logic                          bk_found;

   assign fr_in_valid = req_tvalid && !clearing;
   assign req_tready  = fr_in_ready && !clearing;

   dht_front #(
      .TABLE_SLOTS(TABLE_SLOTS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (fr_in_valid),
      .in_ready (fr_in_ready),
      .in_op    (req_tuser),
      .in_key   (req_tdata[dht_pkg::KEY_WIDTH-1:0]),
      .out_valid(fr_out_valid),
      .out_ready(fr_out_ready),
      .out_op   (fr_op),
      .out_key  (fr_key),
      .out_pos  (fr_pos),
      .out_step (fr_step)
   );

   assign q_in_data = {fr_op, fr_key, fr_pos, fr_step};

   dht_queue #(
      .WIDTH(QW),
      .DEPTH(dht_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_valid (fr_out_valid),
      .in_ready (fr_out_ready),
      .in_data  (q_in_data),
      .out_valid(q_out_valid),
      .out_ready(q_out_ready),
      .out_data (q_out_data)
   );

   dht_back #(
      .TABLE_SLOTS(TABLE_SLOTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_out_valid),
      .in_ready  (q_out_ready),
      .in_op     (q_out_data[QW-1 -: dht_pkg::OP_WIDTH]),
      .in_key    (q_out_data[2*AW +: dht_pkg::KEY_WIDTH]),
      .in_pos    (q_out_data[AW +: AW]),
      .in_step   (q_out_data[AW-1:0]),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_status(bk_status),
      .rsp_found (bk_found),
      .clearing  (clearing)
   );

   assign rsp_tdata = {5'b0, bk_found, bk_status};

   a_no_request_while_clearing: assert property (
      @(posedge clock) disable iff (reset) clearing |-> !req_tready
   ) else $error("request accepted during the clearing pass");

   a_no_response_while_clearing: assert property (
      @(posedge clock) disable iff (reset) clearing |-> !rsp_tvalid
   ) else $error("response presented during the clearing pass");

   a_duplicate_implies_found: assert property (
      @(posedge clock) disable iff (reset)
         (rsp_tvalid && rsp_tdata[1:0] == dht_pkg::ST_DUPLICATE) |-> rsp_tdata[2]
   ) else $error("duplicate status without found flag");

   a_not_found_clears_found: assert property (
      @(posedge clock) disable iff (reset)
         (rsp_tvalid && rsp_tdata[1:0] == dht_pkg::ST_NOT_FOUND) |-> !rsp_tdata[2]
   ) else $error("not-found status with found flag set");

endmodule

// ===== tb/double_hash_checker.sv =====
// Checker for the double-hashing key table: predicts each answer and compares the results.
`timescale 1ns / 100ps

module double_hash_checker #(
   parameter int SLOTS = dht_pkg::TABLE_SLOTS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,
   output int          failures,
   output int          awaited
);

   localparam int KW = dht_pkg::KEY_WIDTH;

   typedef struct {
      logic [dht_pkg::OP_WIDTH-1:0] op;
      logic [KW-1:0]                key;
      dht_pkg::status_type          status;
      logic                         found;
   } answer_type;

   dht_pkg::tag_type slot_state [SLOTS];
   logic [KW-1:0]    slot_value [SLOTS];
   int               key_count;
   answer_type       answer_queue [$];

   task automatic log_failure(input string msg);
      failures++;
      if (failures <= 10) begin
         $display("%0t: %s", $time, msg);
      end
   endtask

   // One pass along the probe path finds both the key and the first reusable slot.
   function automatic void walk_path(input logic [KW-1:0] k, output bit hit,
                                     output int hit_at, output bit has_free,
                                     output int free_at);
      int unsigned pos;
      int unsigned stride;
      pos      = k % SLOTS;
      stride   = (SLOTS - 1) - (k % (SLOTS - 1));
      hit      = 1'b0;
      hit_at   = 0;
      has_free = 1'b0;
      free_at  = 0;
      for (int n = 0; n < SLOTS; n++) begin
         if (slot_state[pos] == dht_pkg::TAG_USED && slot_value[pos] == k) begin
            hit    = 1'b1;
            hit_at = pos;
            return;
         end
         if (slot_state[pos] != dht_pkg::TAG_USED && !has_free) begin
            has_free = 1'b1;
            free_at  = pos;
         end
         if (slot_state[pos] == dht_pkg::TAG_EMPTY) begin
            return;
         end
         pos = (pos + stride) % SLOTS;
      end
   endfunction

   always @(posedge clock) begin : track
      answer_type head;
      answer_type fresh;
      bit         hit;
      bit         has_free;
      int         hit_at;
      int         free_at;
      if (reset) begin
         for (int s = 0; s < SLOTS; s++) begin
            slot_state[s] = dht_pkg::TAG_EMPTY;
            slot_value[s] = '0;
         end
         key_count = 0;
         answer_queue.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (answer_queue.size() == 0) begin
               log_failure($sformatf("result 0x%02h arrived with no request waiting",
                                     rsp_tdata));
            end else begin
               head = answer_queue.pop_front();
               if (rsp_tdata[1:0] !== head.status || rsp_tdata[2] !== head.found) begin
                  log_failure($sformatf(
                     "op %0d key 0x%08h: expected status %0d found %0b, got status %0d found %0b",
                     head.op, head.key, head.status, head.found, rsp_tdata[1:0], rsp_tdata[2]));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            fresh.op  = req_tuser;
            fresh.key = req_tdata[KW-1:0];
            walk_path(fresh.key, hit, hit_at, has_free, free_at);
            fresh.found = hit;
            case (fresh.op)
               dht_pkg::OP_INSERT: begin
                  if (key_count >= SLOTS) begin
                     fresh.status = dht_pkg::ST_FULL;
                  end else if (hit) begin
                     fresh.status = dht_pkg::ST_DUPLICATE;
                  end else if (has_free) begin
                     slot_state[free_at] = dht_pkg::TAG_USED;
                     slot_value[free_at] = fresh.key;
                     key_count++;
                     fresh.status = dht_pkg::ST_DONE;
                  end else begin
                     fresh.status = dht_pkg::ST_FULL;
                  end
               end
               dht_pkg::OP_DELETE: begin
                  if (hit) begin
                     slot_state[hit_at] = dht_pkg::TAG_TOMB;
                     if (key_count > 0) begin
                        key_count--;
                     end
                     fresh.status = dht_pkg::ST_DONE;
                  end else begin
                     fresh.status = dht_pkg::ST_NOT_FOUND;
                  end
               end
               default: begin
                  fresh.status = hit ? dht_pkg::ST_DONE : dht_pkg::ST_NOT_FOUND;
               end
            endcase
            answer_queue.push_back(fresh);
         end
      end
      awaited <= answer_queue.size();
   end

endmodule

// ===== tb/testbench.sv =====
// Top of the testbench for the double-hashing key table: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;

   localparam int                OW        = dht_pkg::OP_WIDTH;
   localparam int                KW        = dht_pkg::KEY_WIDTH;
   localparam logic [OW-1:0]     OP_UNUSED = 2'd3;
   localparam logic [KW-1:0]     FILL_BASE = 31'h7F00_0000;
   localparam logic [KW-1:0]     KEY_MAX   = 31'h7FFF_FFFF;
   localparam int                HOT_COUNT = 96;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // key [30:0], zero [31]
   logic [1:0]  req_tuser;   // operation [1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // status [1:0], found [2], zero [7:3]
   int          failures;
   int          awaited;

   bit          quiet;
   bit          hold_results;
   logic [KW-1:0] hot_keys [HOT_COUNT];

   double_hash_table u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   double_hash_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .failures   (failures),
      .awaited    (awaited)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   task automatic offer(input logic [OW-1:0] op, input logic [KW-1:0] k);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {1'b0, k};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (awaited != 0) begin
         @(posedge clock);
      end
   endtask

   function automatic logic [OW-1:0] pick_op();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
         return dht_pkg::OP_INSERT;
      end else if (roll < 65) begin
         return dht_pkg::OP_SEARCH;
      end else if (roll < 95) begin
         return dht_pkg::OP_DELETE;
      end
      return OP_UNUSED;
   endfunction

   function automatic logic [KW-1:0] pick_key();
      if ($urandom_range(0, 3) != 0) begin
         return hot_keys[$urandom_range(0, HOT_COUNT - 1)];
      end
      return KW'($urandom());
   endfunction

   initial begin : results_side
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) begin
         @(posedge clock);
      end
      forever begin
         if (hold_results) begin
            rsp_tready <= 1'b0;
            repeat (600) @(posedge clock);
            hold_results = 1'b0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int unsigned residues [8];
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= dht_pkg::OP_SEARCH;
      quiet        = 1'b0;
      hold_results = 1'b0;
      foreach (residues[r]) begin
         residues[r] = $urandom_range(0, dht_pkg::TABLE_SLOTS - 1);
      end
      foreach (hot_keys[h]) begin
         hot_keys[h] = KW'(residues[h % 8]
                           + dht_pkg::TABLE_SLOTS * $urandom_range(0, 2_000_000));
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Empty table, key extremes, collisions on a shared first probe and tombstones.
      offer(dht_pkg::OP_SEARCH, '0);
      offer(dht_pkg::OP_DELETE, '0);
      offer(dht_pkg::OP_INSERT, '0);
      offer(dht_pkg::OP_INSERT, '0);
      offer(dht_pkg::OP_INSERT, KEY_MAX);
      offer(dht_pkg::OP_SEARCH, KEY_MAX);
      offer(OP_UNUSED, KEY_MAX);
      offer(OP_UNUSED, 31'd12345);
      offer(dht_pkg::OP_INSERT, 31'd1021);
      offer(dht_pkg::OP_INSERT, 31'd2042);
      offer(dht_pkg::OP_DELETE, 31'd1021);
      offer(dht_pkg::OP_SEARCH, 31'd2042);
      offer(dht_pkg::OP_DELETE, 31'd1021);
      offer(dht_pkg::OP_INSERT, 31'd2042);
      offer(dht_pkg::OP_INSERT, 31'd3063);
      offer(dht_pkg::OP_SEARCH, 31'd1021);
      // Keys 5 and 1041425 share both the first probe and the step.
      offer(dht_pkg::OP_INSERT, 31'd5);
      offer(dht_pkg::OP_INSERT, 31'd1041425);
      offer(dht_pkg::OP_DELETE, 31'd5);
      offer(dht_pkg::OP_SEARCH, 31'd1041425);
      offer(dht_pkg::OP_INSERT, 31'd5);
      offer(dht_pkg::OP_INSERT, 31'h5555_5555);
      offer(dht_pkg::OP_INSERT, 31'h2AAA_AAAA);
      offer(dht_pkg::OP_DELETE, 31'h5555_5555);
      settle();

      // The last part runs without idling from request 600 on and mixes in a run of distinct keys.
      for (int i = 0; i < 776; i++) begin
         if (i == 150) begin
            hold_results = 1'b1;
         end
         if (i == 350) begin
            settle();
         end
         if (i == 600) begin
            quiet = 1'b1;
         end
         if (i >= 600 && $urandom_range(0, 1) == 0) begin
            offer(dht_pkg::OP_INSERT, FILL_BASE + KW'(i));
         end else begin
            offer(pick_op(), pick_key());
         end
      end

      settle();
      repeat (100) @(posedge clock);
      if (failures == 0 && awaited == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin : watchdog
      #250_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
